### src/sacl_pkg.sv
// Shared types and constants of the set-associative write-back cache tag store.
`default_nettype none
package sacl_pkg;

  // Operation codes of a transaction.
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_INVAL = 2'd2;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned WAYOUT_W = 2;

  // Controller commands to the datapath.
  typedef struct packed {
    logic capture;  // latch the request and start the set read
    logic update;   // compare, decide and write the set back
  } sacl_cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic clearing;  // valid/dirty clearing pass still running
  } sacl_status_t;

endpackage
`default_nettype wire

### src/sacl_ctrl.sv
// Controller state machine of the cache tag store.
`default_nettype none
module sacl_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start,
  input  sacl_pkg::sacl_status_t status_i,
  output logic                   busy,
  output sacl_pkg::sacl_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q;

  // Busy while clearing or while a transaction is in its lookup cycle.
  assign busy = (state_q != ST_IDLE);
  assign cmd_o.capture = (state_q == ST_IDLE) && start;
  assign cmd_o.update  = (state_q == ST_LOOKUP);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      case (state_q)
        ST_CLEAR:  if (!status_i.clearing) state_q <= ST_IDLE;
        ST_IDLE:   if (start) state_q <= ST_LOOKUP;
        ST_LOOKUP: state_q <= ST_IDLE;
        default:   state_q <= ST_CLEAR;
      endcase
    end
  end

  // The lookup state is never held, and every capture is followed by an update.
  a_lookup_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> !cmd_o.update) else $error("lookup longer than one cycle");
  a_capture_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.update) else $error("capture not followed by update");
  a_busy_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> busy) else $error("update while not busy");

endmodule
`default_nettype wire

### src/sacl_dp.sv
// Datapath of the cache tag store: set memories, compare, victim pick, update.
`default_nettype none
module sacl_dp #(
  parameter int unsigned NUM_SETS   = 256,
  parameter int unsigned WAYS       = 4,
  parameter int unsigned LINE_BYTES = 64
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  sacl_pkg::sacl_cmd_t           cmd_i,
  input  wire  [1:0]                    func_i,
  input  wire  [sacl_pkg::ADDR_W-1:0]   addr_i,
  output sacl_pkg::sacl_status_t        status_o,
  output logic                          done_o,
  output logic                          hit_o,
  output logic                          write_back_o,
  output logic [sacl_pkg::WAYOUT_W-1:0] way_used_o
);

  localparam int unsigned OFF_BITS = $clog2(LINE_BYTES + 1) - 1;
  localparam int unsigned IDX_BITS = $clog2(NUM_SETS + 1) - 1;
  localparam int unsigned SETS_P2  = 1 << IDX_BITS;
  localparam int unsigned IDX_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int unsigned TAG_W    = sacl_pkg::ADDR_W - OFF_BITS - IDX_BITS;
  localparam int unsigned WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned STW      = sacl_pkg::STAMP_W;

  // Per-set memories; one row holds all ways of a set.
  logic [WAYS-1:0][TAG_W-1:0] tag_mem   [SETS_P2];
  logic [WAYS-1:0][STW-1:0]   stamp_mem [SETS_P2];
  logic [WAYS-1:0]            valid_mem [SETS_P2];
  logic [WAYS-1:0]            dirty_mem [SETS_P2];

  logic [WAYS-1:0][TAG_W-1:0] tag_rd_q;
  logic [WAYS-1:0][STW-1:0]   stamp_rd_q;
  logic [WAYS-1:0]            valid_rd_q, dirty_rd_q;

  logic [1:0]       func_q;
  logic [TAG_W-1:0] tag_q;
  logic [IDX_W-1:0] set_q, set_now;
  logic [STW-1:0]   count_q;
  logic [IDX_W:0]   clr_q;
  logic             clearing;

  assign clearing = (clr_q < (IDX_W+1)'(SETS_P2));
  assign status_o.clearing = clearing;

  // Request fields.
  generate
    if (IDX_BITS > 0) begin : g_idx
      assign set_now = addr_i[OFF_BITS +: IDX_W];
    end else begin : g_noidx
      assign set_now = '0;
    end
  endgenerate

  // Capture the request and read the set.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q     <= func_i;
      tag_q      <= addr_i[sacl_pkg::ADDR_W-1 -: TAG_W];
      set_q      <= set_now;
      tag_rd_q   <= tag_mem[set_now];
      stamp_rd_q <= stamp_mem[set_now];
      valid_rd_q <= valid_mem[set_now];
      dirty_rd_q <= dirty_mem[set_now];
    end
  end

  // Decide: hit search, first invalid way, LRU minimum.
  logic             found, got_inv, is_acc, do_fill;
  logic [WAY_W-1:0] hit_way, inv_way, lru_way, vic_way, sel_way;
  logic [STW-1:0]   min_st, count_n;
  always_comb begin
    found = 1'b0; hit_way = '0;
    got_inv = 1'b0; inv_way = '0;
    min_st = '1; lru_way = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (valid_rd_q[j] && tag_rd_q[j] == tag_q) begin
        found = 1'b1; hit_way = WAY_W'(j);
      end
      if (!valid_rd_q[j]) begin
        got_inv = 1'b1; inv_way = WAY_W'(j);
      end
    end
    for (int j = 0; j < WAYS; j++) begin
      if (stamp_rd_q[j] <= min_st) begin
        min_st = stamp_rd_q[j]; lru_way = WAY_W'(j);
      end
    end
    vic_way = got_inv ? inv_way : lru_way;
    is_acc  = (func_q == sacl_pkg::FUNC_READ) || (func_q == sacl_pkg::FUNC_WRITE);
    do_fill = is_acc && !found;
    sel_way = found ? hit_way : vic_way;
    count_n = count_q + 1'b1;
  end

  // Write the set back and register the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      clr_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      done_o <= cmd_i.update;
      if (clearing) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.update && is_acc) begin
        count_q <= count_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      valid_mem[clr_q[IDX_W-1:0]] <= '0;
      dirty_mem[clr_q[IDX_W-1:0]] <= '0;
    end else if (cmd_i.update) begin
      if (is_acc) begin
        stamp_mem[set_q][sel_way] <= count_n;
        if (do_fill) begin
          tag_mem[set_q][sel_way] <= tag_q;
          valid_mem[set_q][sel_way] <= 1'b1;
          dirty_mem[set_q][sel_way] <= (func_q == sacl_pkg::FUNC_WRITE);
        end else if (func_q == sacl_pkg::FUNC_WRITE) begin
          dirty_mem[set_q][sel_way] <= 1'b1;
        end
      end else if (func_q == sacl_pkg::FUNC_INVAL && found) begin
        valid_mem[set_q][hit_way] <= 1'b0;
        dirty_mem[set_q][hit_way] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_o        <= found && (is_acc || func_q == sacl_pkg::FUNC_INVAL);
      write_back_o <= (do_fill && valid_rd_q[vic_way] && dirty_rd_q[vic_way])
                   || (func_q == sacl_pkg::FUNC_INVAL && found && dirty_rd_q[hit_way]);
      way_used_o   <= (is_acc || (func_q == sacl_pkg::FUNC_INVAL && found))
                    ? sacl_pkg::WAYOUT_W'(32'(sel_way)) : '0;
    end
  end

  // The counter only moves on read and write transactions.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && !is_acc) |=> $stable(count_q)) else $error("count moved");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> done_o) else $error("result missing");
  a_noclr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> !clearing) else $error("update during clear");

endmodule
`default_nettype wire

### src/set_assoc_cache_lru_writeback_top.sv
// Top level of the set-associative write-back cache tag store with LRU.
// Results: the request is registered with the set read when start is accepted; the
// set is compared and written back in the lookup state, and done_o is registered
// with the result at its end. A new start is taken only when idle, after the lookup.
// After reset a clearing pass over NUM_SETS (rounded down to a power of two) sets
// runs; busy stays high until the controller then enters idle. The receiver cannot stall results.
`default_nettype none
module set_assoc_cache_lru_writeback_top #(
  parameter int unsigned NUM_SETS   = 256,
  parameter int unsigned WAYS       = 4,
  parameter int unsigned LINE_BYTES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  func_i,
  input  wire  [31:0] addr_i,
  output logic        done_o,
  output logic        hit_o,
  output logic        write_back_o,
  output logic [1:0]  way_used_o
);

  sacl_pkg::sacl_cmd_t    cmd;
  sacl_pkg::sacl_status_t status;

  sacl_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .status_i(status), .busy, .cmd_o(cmd)
  );

  sacl_dp #(.NUM_SETS(NUM_SETS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .func_i, .addr_i, .status_o(status),
    .done_o, .hit_o, .write_back_o, .way_used_o
  );

endmodule
`default_nettype wire
